// ----- rtl/mexp_pkg.sv -----
// Package for the modular exponentiation core: control word layout and microcode program.
package mexp_pkg;

    localparam int PC_W   = 4;
    localparam int ACT_W  = 3;
    localparam int SRC_W  = 2;
    localparam int COND_W = 3;

    typedef logic [PC_W-1:0]   pc_t;
    typedef logic [ACT_W-1:0]  act_t;
    typedef logic [SRC_W-1:0]  src_t;
    typedef logic [COND_W-1:0] cond_t;

    typedef struct packed {
        act_t  act;
        src_t  src;
        cond_t cond;
        pc_t   target;
    } ctrl_word_t;

    localparam act_t ACT_NONE   = 3'd0;
    localparam act_t ACT_ACCEPT = 3'd1;
    localparam act_t ACT_START  = 3'd2;
    localparam act_t ACT_WR_B   = 3'd3;
    localparam act_t ACT_WR_R   = 3'd4;
    localparam act_t ACT_WR_BSH = 3'd5;
    localparam act_t ACT_OUT    = 3'd6;

    localparam src_t SRC_RED  = 2'd0;
    localparam src_t SRC_MULR = 2'd1;
    localparam src_t SRC_SQR  = 2'd2;

    localparam cond_t COND_NEVER    = 3'd0;
    localparam cond_t COND_ALWAYS   = 3'd1;
    localparam cond_t COND_NO_IN    = 3'd2;
    localparam cond_t COND_M_ZERO   = 3'd3;
    localparam cond_t COND_BUSY     = 3'd4;
    localparam cond_t COND_E_ZERO   = 3'd5;
    localparam cond_t COND_E_LSB0   = 3'd6;
    localparam cond_t COND_OUT_FULL = 3'd7;

    localparam pc_t ST_IDLE     = 4'd0;
    localparam pc_t ST_CHK_M    = 4'd1;
    localparam pc_t ST_RED_GO   = 4'd2;
    localparam pc_t ST_RED_WAIT = 4'd3;
    localparam pc_t ST_RED_WR   = 4'd4;
    localparam pc_t ST_LOOP     = 4'd5;
    localparam pc_t ST_BIT      = 4'd6;
    localparam pc_t ST_MUL_GO   = 4'd7;
    localparam pc_t ST_MUL_WAIT = 4'd8;
    localparam pc_t ST_MUL_WR   = 4'd9;
    localparam pc_t ST_SQR_GO   = 4'd10;
    localparam pc_t ST_SQR_WAIT = 4'd11;
    localparam pc_t ST_SQR_WR   = 4'd12;
    localparam pc_t ST_OUT      = 4'd13;

    function automatic ctrl_word_t ucode(pc_t pc);
        ctrl_word_t w;
        w = '{act: ACT_NONE, src: SRC_RED, cond: COND_ALWAYS, target: ST_IDLE};
        case (pc)
            ST_IDLE:     w = '{ACT_ACCEPT, SRC_RED,  COND_NO_IN,    ST_IDLE};
            ST_CHK_M:    w = '{ACT_NONE,   SRC_RED,  COND_M_ZERO,   ST_OUT};
            ST_RED_GO:   w = '{ACT_START,  SRC_RED,  COND_NEVER,    ST_IDLE};
            ST_RED_WAIT: w = '{ACT_NONE,   SRC_RED,  COND_BUSY,     ST_RED_WAIT};
            ST_RED_WR:   w = '{ACT_WR_B,   SRC_RED,  COND_NEVER,    ST_IDLE};
            ST_LOOP:     w = '{ACT_NONE,   SRC_RED,  COND_E_ZERO,   ST_OUT};
            ST_BIT:      w = '{ACT_NONE,   SRC_RED,  COND_E_LSB0,   ST_SQR_GO};
            ST_MUL_GO:   w = '{ACT_START,  SRC_MULR, COND_NEVER,    ST_IDLE};
            ST_MUL_WAIT: w = '{ACT_NONE,   SRC_MULR, COND_BUSY,     ST_MUL_WAIT};
            ST_MUL_WR:   w = '{ACT_WR_R,   SRC_MULR, COND_NEVER,    ST_IDLE};
            ST_SQR_GO:   w = '{ACT_START,  SRC_SQR,  COND_NEVER,    ST_IDLE};
            ST_SQR_WAIT: w = '{ACT_NONE,   SRC_SQR,  COND_BUSY,     ST_SQR_WAIT};
            ST_SQR_WR:   w = '{ACT_WR_BSH, SRC_SQR,  COND_ALWAYS,   ST_LOOP};
            ST_OUT:      w = '{ACT_OUT,    SRC_RED,  COND_OUT_FULL, ST_OUT};
            default:     w = '{ACT_NONE,   SRC_RED,  COND_ALWAYS,   ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/mexp_mulmod.sv -----
// Serial modular multiplier: one multiplier bit per cycle, doubling and adding with reduction.
module mexp_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] m,
    output logic             busy,
    output logic [WIDTH-1:0] result
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] sh_reg, sh_next;

    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] m1;
    logic [WIDTH+1:0] m2;
    logic [WIDTH-1:0] step_val;

    always_comb
    begin
        m1  = {2'b00, m};
        m2  = {1'b0, m, 1'b0};
        sum = {1'b0, acc_reg, 1'b0} + {2'b00, (sh_reg[WIDTH-1] ? a_reg : '0)};
        if (sum >= m2)
        begin
            step_val = WIDTH'(sum - m2);
        end
        else if (sum >= m1)
        begin
            step_val = WIDTH'(sum - m1);
        end
        else
        begin
            step_val = sum[WIDTH-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        sh_next   = sh_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            a_next    = a;
            sh_next   = b;
        end
        else if (busy_reg)
        begin
            acc_next = step_val;
            sh_next  = {sh_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        sh_reg  <= sh_next;
    end

    assign busy   = busy_reg;
    assign result = acc_reg;

endmodule

// ----- rtl/modular_exponentiation_core.sv -----
// Top level of the modular exponentiation core: microcoded sequencer, registers and ports.
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/tready        base_value, exponent
//  m_axis    out        m_axis_tvalid/tready        power_mod
//  cfg       in         cfg_wr_en                   modulus
//
// A new beat is taken only at the idle step, once the previous item has left the output step;
// a zero modulus goes from the check step straight to the output step. The serial multiplier
// works one multiplier bit per cycle while it is busy.
// Reset sets the modulus to 1 and returns the sequencer to its idle step.
// A result waits in the output register while the next beat is taken; the sequencer stalls
// at its output step only while that register is still full.
module modular_exponentiation_core
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [WIDTH-1:0]               cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // base_value, exponent
    input  logic [((2*WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // power_mod
    output logic [((WIDTH+7)/8)*8-1:0]     m_axis_tdata
);

    localparam int OUT_W = ((WIDTH + 7) / 8) * 8;

    ctrl_word_t       cw;
    pc_t              pc_reg, pc_next;
    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] e_reg, e_next;
    logic [WIDTH-1:0] r_reg, r_next;
    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] out_data_reg, out_data_next;

    logic             in_accept;
    logic             out_full;
    logic             cond_true;
    logic             mul_start;
    logic [WIDTH-1:0] mul_a;
    logic [WIDTH-1:0] mul_b;
    logic             mul_busy;
    logic [WIDTH-1:0] mul_result;

    assign cw            = ucode(pc_reg);
    assign s_axis_tready = (cw.act == ACT_ACCEPT);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_full      = out_valid_reg && !m_axis_tready;
    assign mul_start     = (cw.act == ACT_START);

    always_comb
    begin
        case (cw.src)
            SRC_RED:
            begin
                mul_a = WIDTH'(1);
                mul_b = b_reg;
            end
            SRC_MULR:
            begin
                mul_a = r_reg;
                mul_b = b_reg;
            end
            SRC_SQR:
            begin
                mul_a = b_reg;
                mul_b = b_reg;
            end
            default:
            begin
                mul_a = b_reg;
                mul_b = b_reg;
            end
        endcase
    end

    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .m      (modulus_reg),
        .busy   (mul_busy),
        .result (mul_result)
    );

    always_comb
    begin
        case (cw.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_NO_IN:    cond_true = !in_accept;
            COND_M_ZERO:   cond_true = (modulus_reg == '0);
            COND_BUSY:     cond_true = mul_busy;
            COND_E_ZERO:   cond_true = (e_reg == '0);
            COND_E_LSB0:   cond_true = !e_reg[0];
            COND_OUT_FULL: cond_true = out_full;
            default:       cond_true = 1'b0;
        endcase
        pc_next = cond_true ? cw.target : pc_reg + 1'b1;
    end

    always_comb
    begin
        b_next         = b_reg;
        e_next         = e_reg;
        r_next         = r_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        case (cw.act)
            ACT_ACCEPT:
            begin
                if (in_accept)
                begin
                    b_next = s_axis_tdata[WIDTH-1:0];
                    e_next = s_axis_tdata[2*WIDTH-1:WIDTH];
                    r_next = (modulus_reg == '0) ? '0 : WIDTH'(1);
                end
            end
            ACT_WR_B:
            begin
                b_next = mul_result;
            end
            ACT_WR_R:
            begin
                r_next = mul_result;
            end
            ACT_WR_BSH:
            begin
                b_next = mul_result;
                e_next = e_reg >> 1;
            end
            ACT_OUT:
            begin
                if (!out_full)
                begin
                    out_data_next  = r_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                b_next = b_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= WIDTH'(1);
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                modulus_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg        <= b_next;
        e_reg        <= e_next;
        r_reg        <= r_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

    a_ready_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !mul_busy)
        else $error("Input accepted while the multiplier is running.");

    a_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_busy |-> (pc_reg == ST_RED_WAIT || pc_reg == ST_MUL_WAIT || pc_reg == ST_SQR_WAIT))
        else $error("Multiplier running outside a wait step.");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(pc_reg == ST_OUT))
        else $error("Result raised without the output step.");

endmodule

// ----- bench/tb_modular_exponentiation_core.sv -----
// Testbench for modular_exponentiation_core: directed and random exponentiations checked against a predictor.
`timescale 1ns / 100ps

module tb_modular_exponentiation_core;

    localparam int W = 32;
    localparam int S_DATA_W = ((2 * W + 7) / 8) * 8;
    localparam int M_DATA_W = ((W + 7) / 8) * 8;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [W-1:0]        cfg_wr_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // base_value, exponent
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // power_mod
    logic [M_DATA_W-1:0] m_axis_tdata;

    logic [W-1:0] expected_power_q[$];
    logic [W-1:0] modulus_now = 1;
    int           error_count = 0;
    bit           idling_on = 1'b1;
    int           hold_off_request = 0;
    int           hold_left = 0;
    int           stall_left = 0;

    modular_exponentiation_core #(
        .WIDTH(W)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [W-1:0] predict_power_mod(input logic [W-1:0] base_value,
                                                       input logic [W-1:0] exponent,
                                                       input logic [W-1:0] modulus);
        logic [63:0] product;
        logic [63:0] square;
        logic [W-1:0] bits_left;
        if (modulus == 0)
        begin
            return '0;
        end
        product = 64'd1;
        square = base_value % modulus;
        bits_left = exponent;
        while (bits_left != 0)
        begin
            if (bits_left[0])
            begin
                product = (product * square) % modulus;
            end
            square = (square * square) % modulus;
            bits_left = bits_left >> 1;
        end
        return product[W-1:0];
    endfunction

    function automatic logic [W-1:0] random_exponent(input int max_len);
        int           len;
        logic [W-1:0] mask;
        len = ($urandom_range(0, 7) == 0) ? max_len : $urandom_range(0, max_len);
        if (len == 0)
        begin
            return '0;
        end
        mask = (len >= W) ? '1 : ((W'(1) << len) - 1);
        return (W'($urandom) & mask) | (W'(1) << (len - 1));
    endfunction

    function automatic logic [W-1:0] random_base();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return W'(1);
            2: return modulus_now - 1;
            3: return modulus_now;
            4: return '1;
            default: return W'($urandom);
        endcase
    endfunction

    // Receiver: checks each result beat and drives tready with stalls and hold-offs.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_power_q.size() == 0)
                begin
                    $error("unexpected result beat: power_mod %0h", m_axis_tdata[W-1:0]);
                    error_count++;
                end
                else if (m_axis_tdata[W-1:0] !== expected_power_q[0])
                begin
                    $error("power_mod: expected %0h, actual %0h",
                           expected_power_q[0], m_axis_tdata[W-1:0]);
                    error_count++;
                    void'(expected_power_q.pop_front());
                end
                else
                begin
                    void'(expected_power_q.pop_front());
                end
            end
            if (hold_off_request > 0)
            begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_operands(input logic [W-1:0] base_value, input logic [W-1:0] exponent);
        int gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= S_DATA_W'({exponent, base_value});
        do @(posedge clk); while (!s_axis_tready);
        expected_power_q.push_back(predict_power_mod(base_value, exponent, modulus_now));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_power_q.size() != 0);
    endtask

    task automatic write_modulus(input logic [W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        modulus_now = value;
    endtask

    task automatic send_random_items(input int count, input int max_len);
        repeat (count)
        begin
            send_operands(random_base(), random_exponent(max_len));
        end
    endtask

    // The modulus after reset is one, so every nonzero exponent gives zero.
    task automatic test_reset_modulus();
        send_operands('0, '0);
        send_operands('1, '0);
        send_operands(W'(5), W'(3));
        send_operands('1, '1);
        wait_for_results();
    endtask

    task automatic test_directed_extremes();
        write_modulus('1);
        send_operands('0, '0);
        send_operands('0, W'(1));
        send_operands('1, '1);
        send_operands(32'hFFFF_FFFE, W'(1));
        send_operands(32'hFFFF_FFFE, W'(2));
        send_operands(W'(2), W'(32));
        send_operands(W'(1), '1);
        send_operands(32'h8000_0000, W'(3));
        wait_for_results();
        write_modulus(32'h8000_0000);
        send_operands(W'(3), '1);
        send_operands(32'h8000_0001, W'(2));
        send_operands('1, W'(1));
        wait_for_results();
        write_modulus(W'(13));
        send_operands(W'(2), W'(12));
        send_operands(W'(26), W'(5));
        send_operands(W'(12), W'(1));
        wait_for_results();
        write_modulus(W'(2));
        send_operands('1, W'(7));
        send_operands(32'hFFFF_FFFE, W'(1));
        wait_for_results();
    endtask

    task automatic test_random_moduli();
        logic [W-1:0] moduli[9];
        moduli[0] = W'(1);
        moduli[1] = W'(2);
        moduli[2] = W'(3);
        moduli[3] = W'(97);
        moduli[4] = W'($urandom_range(1, 65535));
        moduli[5] = 32'h8000_0000;
        moduli[6] = W'($urandom);
        moduli[7] = 32'hFFFF_FFFB;
        moduli[8] = '1;
        if (moduli[6] == 0)
        begin
            moduli[6] = W'(1);
        end
        foreach (moduli[i])
        begin
            write_modulus(moduli[i]);
            send_random_items(25, W);
            wait_for_results();
        end
    endtask

    // A long hold-off on the result side fills the block so that it stops taking beats.
    task automatic test_output_backpressure();
        write_modulus(W'($urandom) | W'(1));
        hold_off_request = 4000;
        send_random_items(8, 6);
        wait_for_results();
    endtask

    task automatic test_sender_pause();
        write_modulus(W'(1_000_003));
        send_random_items(5, W);
        wait_for_results();
        send_random_items(5, 12);
        wait_for_results();
    endtask

    task automatic test_without_idling();
        idling_on = 1'b0;
        write_modulus(W'($urandom) | 32'h8000_0000);
        send_random_items(30, W);
        wait_for_results();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_modulus();
        test_directed_extremes();
        test_random_moduli();
        test_output_backpressure();
        test_sender_pause();
        test_without_idling();
        repeat (2400) @(posedge clk);
        if (error_count == 0 && expected_power_q.size() == 0)
        begin
            $display("tb_modular_exponentiation_core passed");
        end
        else
        begin
            $display("tb_modular_exponentiation_core failed");
        end
        $finish;
    end

    initial
    begin
        #(30_000_000);
        $display("tb_modular_exponentiation_core failed");
        $finish;
    end

endmodule
